// File: design/mkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkd_pkg
// shared types, register indexes and the morse tree rom for the key decoder
// ----------------------------------------------------------------------------
package mkd_pkg;

   // result kinds
   typedef enum logic [1:0] {
      EVT_DOT    = 2'd0,
      EVT_DASH   = 2'd1,
      EVT_LETTER = 2'd2
   } event_kind_type;

   // configuration register indexes
   localparam logic [1:0] CSR_DASH_MIN    = 2'd0;
   localparam logic [1:0] CSR_ELEMENT_GAP = 2'd1;
   localparam logic [1:0] CSR_LETTER_GAP  = 2'd2;

   // register reset values
   localparam logic [7:0] DASH_MIN_RST    = 8'd3;
   localparam logic [7:0] ELEMENT_GAP_RST = 8'd40;
   localparam logic [7:0] LETTER_GAP_RST  = 8'd80;

   // counter limits and tree layout
   localparam logic [7:0]        LOW_MAX    = 8'd255;
   localparam logic signed [8:0] PRESS_MAX  = 9'sd255;
   localparam logic signed [8:0] PRESS_IDLE = -9'sd1;
   localparam logic [4:0]        NODE_ROOT  = 5'd1;

   typedef struct packed {
      event_kind_type event_kind;
      logic [6:0]     letter_code;
      logic           letter_invalid;
   } result_type;

   // heap-indexed tree: root 1, left child 2n (dot), right child 2n+1 (dash)
   // zero marks a node that is not part of the alphabet
   function automatic logic [6:0] tree_rom(input logic [4:0] node);
      logic [6:0] ch;
      case (node)
         5'd1:    ch = 7'h20; // space
         5'd2:    ch = 7'h45; // E
         5'd3:    ch = 7'h54; // T
         5'd4:    ch = 7'h49; // I
         5'd5:    ch = 7'h41; // A
         5'd6:    ch = 7'h4E; // N
         5'd7:    ch = 7'h4D; // M
         5'd8:    ch = 7'h53; // S
         5'd9:    ch = 7'h55; // U
         5'd10:   ch = 7'h52; // R
         5'd11:   ch = 7'h57; // W
         5'd12:   ch = 7'h44; // D
         5'd13:   ch = 7'h4B; // K
         5'd14:   ch = 7'h47; // G
         5'd15:   ch = 7'h4F; // O
         5'd16:   ch = 7'h48; // H
         5'd17:   ch = 7'h56; // V
         5'd18:   ch = 7'h46; // F
         5'd20:   ch = 7'h4C; // L
         5'd22:   ch = 7'h50; // P
         5'd23:   ch = 7'h4A; // J
         5'd24:   ch = 7'h42; // B
         5'd25:   ch = 7'h58; // X
         5'd26:   ch = 7'h43; // C
         5'd27:   ch = 7'h59; // Y
         5'd28:   ch = 7'h5A; // Z
         5'd29:   ch = 7'h51; // Q
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: design/morse_key_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_decoder_unit
// decodes a sampled morse key into dot, dash and letter events
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                    handshake
//  req      in         key_level                                  req_valid / req_ready
//  rsp      out        event_kind, letter_code, letter_invalid    rsp_valid / rsp_ready
//  csr      in         index (0 dash min, 1 element gap, 2 letter gap), wdata
//
//  one key sample per cycle while req_ready is high; the counters and the
//  tree step are combinational and a result is registered at the edge that
//  takes the sample, in the output register or, while that one holds an
//  untaken result, in the one skid entry; req_ready drops only while both
//  hold a result, so one untaken result does not stall the input
//  synchronous active-high reset: counters idle, walk at the tree root,
//  registers back to 3 / 40 / 80; csr writes are always taken
//
module morse_key_decoder_unit (
   input  logic                        clock,
   input  logic                        reset,
   // key samples
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_key_level,
   // decoded events
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mkd_pkg::event_kind_type     rsp_event_kind,
   output logic [6:0]                  rsp_letter_code,
   output logic                        rsp_letter_invalid,
   // configuration writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [7:0]                  csr_wdata
);
   import mkd_pkg::*;

   // configuration registers
   logic [7:0] dash_min_ff, element_gap_ff, letter_gap_ff;

   // decoder state
   logic signed [8:0] press_ff, press_in;
   logic [7:0]        low_ff, low_in;
   logic [4:0]        node_ff, node_in;
   logic              inval_ff, inval_in;

   // result staging: output register and skid entry
   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;

   // per-sample combinational results
   logic              accept, pop, has_result;
   result_type        result;
   logic signed [8:0] press_up;
   logic [7:0]        low_up;
   logic              counting, dash;
   logic [4:0]        step_node;
   logic              step_inval;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_min_ff    <= DASH_MIN_RST;
         element_gap_ff <= ELEMENT_GAP_RST;
         letter_gap_ff  <= LETTER_GAP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DASH_MIN:    dash_min_ff    <= csr_wdata;
            CSR_ELEMENT_GAP: element_gap_ff <= csr_wdata;
            CSR_LETTER_GAP:  letter_gap_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // one tree step: dot goes left, dash goes right; stepping off the
   // alphabet or below the fourth level freezes the walk and flags it
   always_comb begin
      step_node  = node_ff;
      step_inval = inval_ff;
      if (!inval_ff) begin
         if (node_ff[4]) begin
            step_inval = 1'b1;
         end else if (tree_rom({node_ff[3:0], dash}) == 7'h00) begin
            step_inval = 1'b1;
         end else begin
            step_node = {node_ff[3:0], dash};
         end
      end
   end

   always_comb begin
      // press count saturates at its top, low count too
      press_up = (press_ff != PRESS_MAX) ? press_ff + 9'sd1 : press_ff;
      low_up   = (low_ff != LOW_MAX) ? low_ff + 8'd1 : low_ff;
      // press count is 0..255 once a press has been seen
      dash     = ({1'b0, press_ff[7:0]} >= {1'b0, dash_min_ff}) || press_ff[8];
      counting = !req_key_level && !press_ff[8];

      press_in   = press_ff;
      low_in     = low_ff;
      node_in    = node_ff;
      inval_in   = inval_ff;
      has_result = 1'b0;
      result     = '{event_kind: EVT_DOT, letter_code: 7'h00, letter_invalid: 1'b0};

      if (req_key_level) begin
         press_in = press_up;
      end else if (counting) begin
         low_in = low_up;
         if (low_up >= letter_gap_ff) begin
            // letter gap: report the node and rearm at the root
            has_result = 1'b1;
            result     = '{event_kind: EVT_LETTER, letter_code: tree_rom(node_ff),
                           letter_invalid: inval_ff};
            node_in    = NODE_ROOT;
            inval_in   = 1'b0;
            press_in   = PRESS_IDLE;
            low_in     = '0;
         end else if (low_up >= element_gap_ff && press_ff != 9'sd0) begin
            // element gap after a press: decide dot or dash and step
            has_result = 1'b1;
            result     = '{event_kind: dash ? EVT_DASH : EVT_DOT,
                           letter_code: tree_rom(step_node),
                           letter_invalid: step_inval};
            node_in    = step_node;
            inval_in   = step_inval;
            press_in   = 9'sd0;
            low_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff <= PRESS_IDLE;
         low_ff   <= '0;
         node_ff  <= NODE_ROOT;
         inval_ff <= 1'b0;
      end else if (accept) begin
         press_ff <= press_in;
         low_ff   <= low_in;
         node_ff  <= node_in;
         inval_ff <= inval_in;
      end
   end

   // output staging; a new result lands in the output register when it is
   // free or being drained, otherwise in the skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept && has_result) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept && has_result) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = out_ff.event_kind;
   assign rsp_letter_code    = out_ff.letter_code;
   assign rsp_letter_invalid = out_ff.letter_invalid;

endmodule

// File: tb/sv/morse_key_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_decoder_unit_tb
// drives key samples through the decoder and checks every dot, dash and
// letter event against a cycle-free software decode of the same samples,
// across several gap and dash settings and with random idling on both sides
// ----------------------------------------------------------------------------
module morse_key_decoder_unit_tb;
   import mkd_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 150;
   // heap-ordered letters, one char per node, '.' marks a node off the alphabet
   localparam logic [255:0] HEAP_LETTERS = ". ETIANMSURWDKGOHVF.L.PJBXCYZQ..";

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_key_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   event_kind_type       rsp_event_kind;
   logic [6:0]           rsp_letter_code;
   logic                 rsp_letter_invalid;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = CSR_DASH_MIN;
   logic [7:0]           csr_wdata = 8'd0;

   // decoder state as the testbench sees it
   logic [7:0]           dash_min_reg    = 8'd3;
   logic [7:0]           element_gap_reg = 8'd40;
   logic [7:0]           letter_gap_reg  = 8'd80;
   logic signed [8:0]    press_cnt = -9'sd1;
   logic [7:0]           low_cnt   = 8'd0;
   logic [4:0]           walk_node = 5'd1;
   logic                 off_tree  = 1'b0;

   logic                 key_samples[$];
   result_type           decoded_events[$];
   result_type           want;
   int                   mismatches = 0;
   int                   sender_gap_pct = 0;
   int                   receiver_stall_pct = 0;
   logic                 rsp_hold = 1'b0;

   morse_key_decoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key_level      (req_key_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_letter_code    (rsp_letter_code),
      .rsp_letter_invalid (rsp_letter_invalid),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ascii letter of a tree node, zero where the node is not in the alphabet
   function automatic logic [6:0] heap_letter(input logic [4:0] idx);
      logic [7:0] ch;
      ch = HEAP_LETTERS[255 - 8 * idx -: 8];
      return (ch == ".") ? 7'd0 : ch[6:0];
   endfunction

   // one key tick through the decoder; queues the event it causes, if any
   function automatic void decode_key_tick(input logic key);
      result_type ev;
      logic       dash;
      logic [4:0] child;
      if (key && press_cnt < 9'sd255)
         press_cnt = press_cnt + 9'sd1;
      // low ticks only count once a press has armed the walk
      if (key || press_cnt < 0)
         return;
      if (low_cnt != 8'd255)
         low_cnt = low_cnt + 8'd1;
      if (low_cnt >= letter_gap_reg) begin
         ev.event_kind     = EVT_LETTER;
         ev.letter_code    = heap_letter(walk_node);
         ev.letter_invalid = off_tree;
         walk_node = 5'd1;
         off_tree  = 1'b0;
         press_cnt = -9'sd1;
         low_cnt   = 8'd0;
         decoded_events.push_back(ev);
      end else if (low_cnt >= element_gap_reg && press_cnt != 0) begin
         dash    = (press_cnt[7:0] >= dash_min_reg);
         low_cnt = 8'd0;
         child   = {walk_node[3:0], dash};
         // once off the tree the walk freezes until the letter closes
         if (!off_tree) begin
            if (walk_node >= 5'd16 || heap_letter(child) == 7'd0)
               off_tree = 1'b1;
            else
               walk_node = child;
         end
         press_cnt = 9'sd0;
         ev.event_kind     = dash ? EVT_DASH : EVT_DOT;
         ev.letter_code    = heap_letter(walk_node);
         ev.letter_invalid = off_tree;
         decoded_events.push_back(ev);
      end
   endfunction

   // driver: one key sample per transfer, random gaps between samples
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            decode_key_tick(req_key_level);
         if (!req_valid || req_ready) begin
            if (key_samples.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
               req_valid     <= 1'b1;
               req_key_level <= key_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: takes events and compares them with the oldest decoded one
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_events.size() == 0) begin
               $error("unexpected event: kind %0d letter %0h invalid %0b",
                      rsp_event_kind, rsp_letter_code, rsp_letter_invalid);
               mismatches++;
            end else begin
               want = decoded_events.pop_front();
               if (rsp_event_kind !== want.event_kind) begin
                  $error("event_kind: expected %0d, got %0d", want.event_kind, rsp_event_kind);
                  mismatches++;
               end
               if (rsp_letter_code !== want.letter_code) begin
                  $error("letter_code: expected %0h, got %0h",
                         want.letter_code, rsp_letter_code);
                  mismatches++;
               end
               if (rsp_letter_invalid !== want.letter_invalid) begin
                  $error("letter_invalid: expected %0b, got %0b",
                         want.letter_invalid, rsp_letter_invalid);
                  mismatches++;
               end
            end
         end
         // a long hold-off from the stimulus process overrides random stalls
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // one register transfer; valid stays up so back-to-back writes do not toggle it
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_DASH_MIN:    dash_min_reg    = val;
         CSR_ELEMENT_GAP: element_gap_reg = val;
         CSR_LETTER_GAP:  letter_gap_reg  = val;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [7:0] dash_min, input logic [7:0] elem_gap,
                             input logic [7:0] letter_gap);
      write_reg(CSR_DASH_MIN, dash_min);
      write_reg(CSR_ELEMENT_GAP, elem_gap);
      write_reg(CSR_LETTER_GAP, letter_gap);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      sender_gap_pct     = (mode == IDLE_SENDER)   ? 55 : (mode == IDLE_BOTH) ? 17 : 0;
      receiver_stall_pct = (mode == IDLE_RECEIVER) ? 55 : (mode == IDLE_BOTH) ? 17 : 0;
   endtask

   task automatic queue_level(input logic lvl, input int n);
      repeat (n) key_samples.push_back(lvl);
   endtask

   // well-formed letter at the current timing, with an occasional split press
   task automatic queue_letter(input int n_elem);
      int len;
      int gap;
      for (int e = 0; e < n_elem; e++) begin
         if ($urandom_range(1))
            len = dash_min_reg + $urandom_range(3);
         else
            len = (dash_min_reg > 1) ? $urandom_range(dash_min_reg - 1, 1) : 1;
         // the first press tick of a letter only lifts the count off idle
         if (e == 0)
            len++;
         if ($urandom_range(7) == 0 && element_gap_reg > 1) begin
            queue_level(1'b1, 1);
            queue_level(1'b0, $urandom_range(element_gap_reg - 1, 1));
         end
         queue_level(1'b1, len);
         gap = (letter_gap_reg > element_gap_reg + 1) ?
               $urandom_range(letter_gap_reg - 1, element_gap_reg) : element_gap_reg;
         queue_level(1'b0, gap);
      end
      queue_level(1'b0, letter_gap_reg + $urandom_range(2));
   endtask

   task automatic queue_noise(input int runs);
      repeat (runs) queue_level(1'($urandom_range(1)), $urandom_range(6, 1));
   endtask

   // every sample sent, every event seen, and the pipeline given time to empty
   task automatic wait_drained();
      do @(posedge clock);
      while (key_samples.size() != 0 || req_valid || decoded_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] d;
      logic [7:0] eg;
      logic [7:0] lg;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // gap with no press, low count carrying across a press, step to an
      // undefined node
      set_timing(8'd3, 8'd2, 8'd4);
      set_idling(IDLE_NONE);
      queue_level(1'b1, 1);
      queue_level(1'b0, 4);
      queue_level(1'b1, 2);
      queue_level(1'b0, 1);
      queue_level(1'b1, 1);
      queue_level(1'b0, 1);
      queue_level(1'b1, 1);
      queue_level(1'b0, 2);
      queue_level(1'b1, 3);
      queue_level(1'b0, 2);
      queue_level(1'b1, 3);
      queue_level(1'b0, 6);
      wait_drained();

      // zero dash threshold and element gap: every element a dash
      set_timing(8'd0, 8'd0, 8'd3);
      queue_level(1'b1, 2);
      queue_level(1'b0, 4);
      wait_drained();

      // zero letter gap: the first counted low tick closes the letter
      set_timing(8'd2, 8'd5, 8'd0);
      queue_level(1'b1, 2);
      queue_level(1'b0, 1);
      wait_drained();

      // largest dash threshold: a long press saturates the press count and
      // still counts as a dash
      set_timing(8'd255, 8'd2, 8'd4);
      set_idling(IDLE_SENDER);
      queue_level(1'b1, 258);
      queue_level(1'b0, 6);
      wait_drained();

      // random timing, mostly well-formed letters, some noise
      for (int p = 0; p < 4; p++) begin
         d  = 8'($urandom_range(5, 1));
         eg = 8'($urandom_range(4, 1));
         lg = 8'($urandom_range(eg + 6, 1));
         set_timing(d, eg, lg);
         set_idling(idle_mode_type'(p % 4));
         queue_letter($urandom_range(6, 1));
         queue_noise(4);
         wait_drained();
      end

      // receiver holds off while short elements keep coming, filling the
      // output stage until the input stalls
      set_timing(8'd2, 8'd1, 8'd3);
      set_idling(IDLE_NONE);
      rsp_hold <= 1'b1;
      repeat (20) begin
         queue_level(1'b1, 2);
         queue_level(1'b0, 1);
      end
      queue_level(1'b0, 4);
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
      wait_drained();

      if (mismatches == 0 && decoded_events.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // hang guard
   initial begin
      #1_500_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
